/* hw/rtl/http_body_chunk_deframer_top_macros.svh */
// http_body_chunk_deframer_top_macros.svh
// concurrent assertion macros shared by the deframer checker; no other dependencies

`ifndef HTTP_BODY_CHUNK_DEFRAMER_TOP_MACROS_SVH
`define HTTP_BODY_CHUNK_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define HBCD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("hbcd assertion failed");

// next-cycle implication, disabled while reset is asserted
`define HBCD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("hbcd assertion failed");

`endif

/* hw/rtl/hbcd_pkg.sv */
// hbcd_pkg.sv
// types, codes and helper functions of the http body chunk deframer; no dependencies

package hbcd_pkg;

	localparam int DEF_MAX_LINE   = 64 * 1024;
	localparam int DEF_COUNT_BITS = 48;
	localparam int CFG_W          = 48;
	localparam int BYTE_W         = 8;
	localparam int STATUS_W       = 3;

	localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

	// line shape codes: size lines use all four, blank lines the first three
	localparam logic [1:0] SH_EMPTY = 2'd0; // nothing yet
	localparam logic [1:0] SH_FIRST = 2'd1; // in digits, or a lone cr
	localparam logic [1:0] SH_REST  = 2'd2; // text past the digits, or other content
	localparam logic [1:0] SH_BAD   = 2'd3; // no leading digit or size overflow

	typedef enum logic [1:0] {
		MODE_CHUNKED = 2'd0,
		MODE_LENGTH  = 2'd1,
		MODE_TO_EOF  = 2'd2,
		MODE_NONE    = 2'd3
	} body_mode_t;

	typedef enum logic [0:0] {
		REG_BODY_MODE   = 1'b0,
		REG_CONTENT_LEN = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_SIZE  = 3'd0,
		PH_DATA  = 3'd1,
		PH_TERM  = 3'd2,
		PH_TRAIL = 3'd3,
		PH_LEN   = 3'd4
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_BUSY    = 3'd0,
		ST_DONE    = 3'd1,
		ST_BADSIZE = 3'd2,
		ST_NOCRLF  = 3'd3,
		ST_LONG    = 3'd4,
		ST_EOF     = 3'd5
	} status_t;

	// word held in the input register
	typedef struct packed {
		logic              vld;
		logic [BYTE_W-1:0] data;
		logic              eos;
	} stage_word_t;

	// hex digit decode: {is_digit, value}
	function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= "0" && b <= "9")
			r = {1'b1, 4'(b - "0")};
		else if (b >= "a" && b <= "f")
			r = {1'b1, 4'(b - "a" + 8'd10)};
		else if (b >= "A" && b <= "F")
			r = {1'b1, 4'(b - "A" + 8'd10)};
		return r;
	endfunction

endpackage

/* hw/rtl/hbcd_if.sv */
// hbcd_if.sv
// valid/ready channel interfaces for input and result words; uses hbcd_pkg

interface hbcd_in_if import hbcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              end_of_stream;

	modport source (output valid, output in_byte, output end_of_stream, input ready);
	modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface hbcd_out_if import hbcd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   out_byte;
	logic                payload_valid;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output out_byte, output payload_valid, output status,
		input ready);
	modport sink   (input valid, input out_byte, input payload_valid, input status,
		output ready);
endinterface

/* hw/rtl/hbcd_in_stage.sv */
// hbcd_in_stage.sv
// input register stage of the deframer; uses hbcd_pkg and hbcd_in_if

module hbcd_in_stage import hbcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	hbcd_in_if.sink     in_ch,
	input  logic        take,
	output stage_word_t word_s1
);

	logic              vld_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              eos_s1;

	// register free, or emptied by the core this cycle
	assign in_ch.ready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			data_s1 <= in_ch.in_byte;
			eos_s1  <= in_ch.end_of_stream;
		end
	end

	assign word_s1 = '{vld: vld_s1, data: data_s1, eos: eos_s1};

endmodule

/* hw/rtl/hbcd_core.sv */
// hbcd_core.sv
// deframer state, configuration registers, next-state logic and result register
// uses hbcd_pkg and hbcd_out_if

module hbcd_core import hbcd_pkg::*; #(
	parameter int MAX_LINE   = DEF_MAX_LINE,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [0:0]        cfg_idx,
	input  logic [CFG_W-1:0]  cfg_data,
	input  stage_word_t       word_s1,
	output logic              take,
	hbcd_out_if.source        out_ch
);

	localparam int LW = $clog2(MAX_LINE + 1);
	localparam logic [LW-1:0] LINE_MAX = LW'(MAX_LINE);

	// configuration
	body_mode_t       body_mode_q;
	logic [CFG_W-1:0] content_len_q;
	logic [COUNT_BITS-1:0] cl_cnt;

	// parser state
	phase_t                phase_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] acc_q;
	logic [LW-1:0]         len_q;
	logic [1:0]            shape_q;
	status_t               outcome_q;

	// next values
	phase_t                ph;
	logic [COUNT_BITS-1:0] rem;
	logic [COUNT_BITS-1:0] acc;
	logic [LW-1:0]         len;
	logic [1:0]            shape;
	status_t               outc;
	logic                  pass;
	logic [4:0]            hex;

	// result register
	logic                vld_s2;
	logic [BYTE_W-1:0]   byte_s2;
	logic                pv_s2;
	logic [STATUS_W-1:0] st_s2;

	generate
		if (COUNT_BITS > CFG_W) begin : g_cl_wide
			assign cl_cnt = {{(COUNT_BITS - CFG_W){1'b0}}, content_len_q};
		end else begin : g_cl_narrow
			assign cl_cnt = content_len_q[COUNT_BITS-1:0];
		end
	endgenerate

	assign take = word_s1.vld && (!vld_s2 || out_ch.ready);
	assign hex  = hex_decode(word_s1.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_mode_q   <= MODE_CHUNKED;
			content_len_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_BODY_MODE:   body_mode_q   <= body_mode_t'(cfg_data[1:0]);
				REG_CONTENT_LEN: content_len_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		ph    = phase_q;
		rem   = rem_q;
		acc   = acc_q;
		len   = len_q;
		shape = shape_q;
		outc  = outcome_q;
		pass  = 1'b0;
		if (outcome_q == ST_BUSY) begin
			unique case (body_mode_q)
				MODE_NONE: begin
					outc = ST_DONE;
				end
				MODE_TO_EOF: begin
					if (word_s1.eos) outc = ST_DONE;
					else pass = 1'b1;
				end
				MODE_LENGTH: begin
					if (phase_q != PH_LEN) begin
						rem = cl_cnt;
						ph  = PH_LEN;
					end
					if (rem == '0) begin
						outc = ST_DONE;
					end else if (word_s1.eos) begin
						outc = ST_EOF;
					end else begin
						pass = 1'b1;
						rem  = rem - 1'b1;
						if (rem == '0) outc = ST_DONE;
					end
				end
				MODE_CHUNKED: begin
					// coming back from length mode restarts at a size line
					if (phase_q == PH_LEN) begin
						ph    = PH_SIZE;
						acc   = '0;
						len   = '0;
						shape = SH_EMPTY;
					end
					if (word_s1.eos) begin
						outc = ST_EOF;
					end else if (ph == PH_DATA) begin
						pass = 1'b1;
						rem  = rem - 1'b1;
						if (rem == '0) begin
							ph    = PH_TERM;
							acc   = '0;
							len   = '0;
							shape = SH_EMPTY;
						end
					end else if (word_s1.data == CHAR_LF) begin
						priority if (ph == PH_SIZE) begin
							if (shape == SH_FIRST || shape == SH_REST) begin
								if (acc == '0) begin
									ph = PH_TRAIL;
								end else begin
									rem = acc;
									ph  = PH_DATA;
								end
								acc   = '0;
								len   = '0;
								shape = SH_EMPTY;
							end else begin
								outc = ST_BADSIZE;
							end
						end else if (ph == PH_TERM) begin
							if (shape == SH_EMPTY || shape == SH_FIRST) begin
								ph    = PH_SIZE;
								acc   = '0;
								len   = '0;
								shape = SH_EMPTY;
							end else begin
								outc = ST_NOCRLF;
							end
						end else begin
							// trailer section: a blank line ends the body
							if (shape == SH_EMPTY || shape == SH_FIRST) begin
								outc = ST_DONE;
							end else begin
								acc   = '0;
								len   = '0;
								shape = SH_EMPTY;
							end
						end
					end else if (len == LINE_MAX) begin
						outc = ST_LONG;
					end else begin
						len = len + 1'b1;
						if (ph == PH_SIZE) begin
							if (shape == SH_EMPTY || shape == SH_FIRST) begin
								priority if (!hex[4]) begin
									shape = (shape == SH_EMPTY) ? SH_BAD : SH_REST;
								end else if (acc[COUNT_BITS-1 -: 4] != 4'd0) begin
									shape = SH_BAD;
								end else begin
									acc   = {acc[COUNT_BITS-5:0], hex[3:0]};
									shape = SH_FIRST;
								end
							end
						end else begin
							if (shape == SH_EMPTY && word_s1.data == CHAR_CR) shape = SH_FIRST;
							else shape = SH_REST;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SIZE;
			rem_q     <= '0;
			acc_q     <= '0;
			len_q     <= '0;
			shape_q   <= SH_EMPTY;
			outcome_q <= ST_BUSY;
		end else if (take) begin
			phase_q   <= ph;
			rem_q     <= rem;
			acc_q     <= acc;
			len_q     <= len;
			shape_q   <= shape;
			outcome_q <= outc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (take) begin
			vld_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s2 <= pass ? word_s1.data : '0;
			pv_s2   <= pass;
			st_s2   <= outc;
		end
	end

	assign out_ch.valid         = vld_s2;
	assign out_ch.out_byte      = byte_s2;
	assign out_ch.payload_valid = pv_s2;
	assign out_ch.status        = st_s2;

endmodule

/* hw/rtl/http_body_chunk_deframer_top.sv */
// http_body_chunk_deframer_top.sv
// top level of the http body chunk deframer
// uses hbcd_pkg, hbcd_in_if, hbcd_out_if, hbcd_in_stage and hbcd_core
//
//   channel  | dir | payload                                  | accepted when
//   ---------+-----+------------------------------------------+----------------------
//   in_ch    | in  | in_byte[7:0], end_of_stream              | valid && ready
//   out_ch   | out | out_byte[7:0], payload_valid, status[2:0]| valid && ready
//   cfg      | in  | cfg_idx[0], cfg_data[47:0]               | cfg_wr_en
//
// one word per cycle unless out_ch stalls; input register feeds the result register
// parser state updates as each word is taken; words wait only on an out_ch stall
// arst_n clears the handshake valids, the parser state and the configuration registers
// a stall on out_ch holds the result register; one more word can sit in the input
// register before in_ch.ready drops

module http_body_chunk_deframer_top import hbcd_pkg::*; #(
	parameter int MAX_LINE   = DEF_MAX_LINE,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	hbcd_in_if.sink          in_ch,
	hbcd_out_if.source       out_ch,
	input  logic             cfg_wr_en,
	input  logic [0:0]       cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);

	// word waiting in the input register
	stage_word_t word_s1;
	// core consumes the input register this cycle
	logic        take;

	hbcd_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.take    (take),
		.word_s1 (word_s1)
	);

	// parser state, config registers and result register
	hbcd_core #(
		.MAX_LINE   (MAX_LINE),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.word_s1   (word_s1),
		.take      (take),
		.out_ch    (out_ch)
	);

endmodule

/* hw/rtl/hbcd_checker.sv */
// hbcd_checker.sv
// port-level assertions for the deframer top and their bind
// uses hbcd_pkg and http_body_chunk_deframer_top_macros.svh

`include "http_body_chunk_deframer_top_macros.svh"

module hbcd_checker import hbcd_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [BYTE_W-1:0]   out_byte,
	input logic                payload_valid,
	input logic [STATUS_W-1:0] status
);

	// first final status seen on the result channel
	logic                final_q;
	logic [STATUS_W-1:0] final_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_q    <= 1'b0;
			final_st_q <= ST_BUSY;
		end else if (out_valid && out_ready && !final_q && status != ST_BUSY) begin
			final_q    <= 1'b1;
			final_st_q <= status;
		end
	end

	`HBCD_ASSERT_IMP(a_zero_byte, clk, arst_n, out_valid && !payload_valid, out_byte == '0)
	`HBCD_ASSERT_IMP(a_pass_status, clk, arst_n, out_valid && payload_valid, status == ST_BUSY || status == ST_DONE)
	`HBCD_ASSERT_IMP(a_sticky, clk, arst_n, out_valid && final_q, status == final_st_q && !payload_valid)
	`HBCD_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(status) && $stable(payload_valid))

endmodule

bind http_body_chunk_deframer_top hbcd_checker u_hbcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_byte      (out_ch.out_byte),
	.payload_valid (out_ch.payload_valid),
	.status        (out_ch.status)
);
